// File: src/mca_pkg.sv
// shared types, constants and modular helper functions for the coefficient alu
// no dependencies; used by every module in src
package mca_pkg;

  localparam int unsigned CoeffBits  = 60;
  localparam int unsigned NumModuli  = 8;
  localparam int unsigned CmdBits    = 3;
  localparam int unsigned SelBits    = 3;
  localparam int unsigned CfgIdxBits = 3;

  typedef logic [CoeffBits-1:0] coeff_t;

  typedef enum logic [CmdBits-1:0] {
    CmdAdd    = 3'd0,
    CmdSub    = 3'd1,
    CmdMul    = 3'd2,
    CmdAddImm = 3'd3,
    CmdSubImm = 3'd4,
    CmdMulImm = 3'd5,
    CmdNeg    = 3'd6,
    CmdNop    = 3'd7
  } cmd_e;

  // control that rides along with every request
  typedef struct packed {
    cmd_e   cmd;
    coeff_t q;
    logic   bypass;   // result comes from byp_val, no arithmetic
    logic   err;
    coeff_t byp_val;
  } ctl_t;

  // one restoring step: shift in a bit and subtract q once
  function automatic coeff_t red_step(coeff_t r, logic b, coeff_t q);
    logic [CoeffBits:0] t;
    t = {r, b};
    if (t >= {1'b0, q}) begin
      t = t - {1'b0, q};
    end
    return t[CoeffBits-1:0];
  endfunction

  // (x + y) mod q for x, y below q
  function automatic coeff_t add_mod(coeff_t x, coeff_t y, coeff_t q);
    logic [CoeffBits:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, q}) begin
      s = s - {1'b0, q};
    end
    return s[CoeffBits-1:0];
  endfunction

  // (x - y) mod q for x, y below q
  function automatic coeff_t sub_mod(coeff_t x, coeff_t y, coeff_t q);
    coeff_t d;
    d = x - y;
    if (x < y) begin
      d = d + q;
    end
    return d;
  endfunction

endpackage

// File: src/mca_reduce.sv
// pipelined reduction of two operands mod q, one bit per stage (restoring)
// depends on mca_pkg
module mca_reduce import mca_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  ctl_t   in_ctl_i,
  input  coeff_t in_x_i,
  input  coeff_t in_y_i,
  output logic   out_valid_o,
  output ctl_t   out_ctl_o,
  output coeff_t out_x_o,
  output coeff_t out_y_o
);

  logic   v_q    [CoeffBits];
  ctl_t   ctl_q  [CoeffBits];
  coeff_t xraw_q [CoeffBits];
  coeff_t yraw_q [CoeffBits];
  coeff_t rx_q   [CoeffBits];
  coeff_t ry_q   [CoeffBits];

  for (genvar k = 0; k < CoeffBits; k++) begin : g_stage
    logic   v_d;
    ctl_t   ctl_d;
    coeff_t xraw_d, yraw_d, rx_d, ry_d;

    // stage k consumes bit CoeffBits-1-k, msb first
    if (k == 0) begin : g_first
      always_comb begin
        v_d    = in_valid_i;
        ctl_d  = in_ctl_i;
        xraw_d = in_x_i;
        yraw_d = in_y_i;
        rx_d   = red_step('0, in_x_i[CoeffBits-1], in_ctl_i.q);
        ry_d   = red_step('0, in_y_i[CoeffBits-1], in_ctl_i.q);
      end
    end else begin : g_next
      always_comb begin
        v_d    = v_q[k-1];
        ctl_d  = ctl_q[k-1];
        xraw_d = xraw_q[k-1];
        yraw_d = yraw_q[k-1];
        rx_d   = red_step(rx_q[k-1], xraw_q[k-1][CoeffBits-1-k], ctl_q[k-1].q);
        ry_d   = red_step(ry_q[k-1], yraw_q[k-1][CoeffBits-1-k], ctl_q[k-1].q);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_d;
      end
    end

    always_ff @(posedge clk_i) begin
      ctl_q[k]  <= ctl_d;
      xraw_q[k] <= xraw_d;
      yraw_q[k] <= yraw_d;
      rx_q[k]   <= rx_d;
      ry_q[k]   <= ry_d;
    end
  end

  assign out_valid_o = v_q[CoeffBits-1];
  assign out_ctl_o   = ctl_q[CoeffBits-1];
  assign out_x_o     = rx_q[CoeffBits-1];
  assign out_y_o     = ry_q[CoeffBits-1];

endmodule

// File: src/mca_mulmod.sv
// pipelined modular multiply, double-and-add over one bit of y per stage
// depends on mca_pkg
module mca_mulmod import mca_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  ctl_t   in_ctl_i,
  input  coeff_t in_x_i,
  input  coeff_t in_y_i,
  output logic   out_valid_o,
  output ctl_t   out_ctl_o,
  output coeff_t out_x_o,
  output coeff_t out_y_o,
  output coeff_t out_prod_o
);

  logic   v_q [CoeffBits];
  ctl_t   ctl_q [CoeffBits];
  coeff_t x_q [CoeffBits];
  coeff_t y_q [CoeffBits];
  coeff_t r_q [CoeffBits];

  for (genvar k = 0; k < CoeffBits; k++) begin : g_stage
    logic   v_d;
    ctl_t   ctl_d;
    coeff_t x_d, y_d, r_prev, r_dbl, r_d;

    if (k == 0) begin : g_first
      always_comb begin
        v_d    = in_valid_i;
        ctl_d  = in_ctl_i;
        x_d    = in_x_i;
        y_d    = in_y_i;
        r_prev = '0;
      end
    end else begin : g_next
      always_comb begin
        v_d    = v_q[k-1];
        ctl_d  = ctl_q[k-1];
        x_d    = x_q[k-1];
        y_d    = y_q[k-1];
        r_prev = r_q[k-1];
      end
    end

    always_comb begin
      r_dbl = add_mod(r_prev, r_prev, ctl_d.q);
      r_d   = y_d[CoeffBits-1-k] ? add_mod(r_dbl, x_d, ctl_d.q) : r_dbl;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_d;
      end
    end

    always_ff @(posedge clk_i) begin
      ctl_q[k] <= ctl_d;
      x_q[k]   <= x_d;
      y_q[k]   <= y_d;
      r_q[k]   <= r_d;
    end
  end

  assign out_valid_o = v_q[CoeffBits-1];
  assign out_ctl_o   = ctl_q[CoeffBits-1];
  assign out_x_o     = x_q[CoeffBits-1];
  assign out_y_o     = y_q[CoeffBits-1];
  assign out_prod_o  = r_q[CoeffBits-1];

endmodule

// File: src/modular_coefficient_alu_top.sv
// top level of the modular coefficient alu: modulus table, entry stage, final select
// depends on mca_pkg, mca_reduce, mca_mulmod
//
// Fully pipelined modular ALU: one request is taken every clock cycle (busy
// stays low) and its result appears on result_o with result_valid_o high for
// exactly one cycle, in request order, after the entry register, the
// bit-serial pipelines and the output register. The pipelines are a restoring
// reduction of the operands mod q, one bit per stage, followed by a
// double-and-add modular multiplier, one multiplier bit per stage; add, sub
// and negate ride through the same stages so every command has the same
// latency. The receiver cannot stall, so there is no back-pressure. The
// selected modulus is captured with the request, so the table may be
// rewritten without disturbing requests in flight; cfg_ready_o is always high.
module modular_coefficient_alu_top import mca_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request
  input  logic                  start,
  output logic                  busy,
  input  logic [CmdBits-1:0]    command_i,
  input  logic [SelBits-1:0]    modulus_select_i,
  input  coeff_t                operand_a_i,
  input  coeff_t                operand_b_i,
  input  coeff_t                immediate_i,
  // result
  output logic                  result_valid_o,
  output coeff_t                result_o,
  output logic                  modulus_error_o,
  // modulus table writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  coeff_t                cfg_data_i
);

  localparam int unsigned Latency = 2 * CoeffBits + 2;

  // modulus table
  coeff_t mod_q [NumModuli];

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  for (genvar m = 0; m < NumModuli; m++) begin : g_mod
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mod_q[m] <= '0;
      end else if (cfg_valid_i && cfg_ready_o &&
                   (cfg_index_i == CfgIdxBits'(m))) begin
        mod_q[m] <= cfg_data_i;
      end
    end
  end

  // entry: look up q, sort out the special cases, pick the second operand
  cmd_e   cmd;
  coeff_t q_sel;
  logic   is_copy, is_mul0, is_nop, q_zero;
  ctl_t   ctl_d;
  coeff_t y_sel;

  always_comb begin
    cmd   = cmd_e'(command_i);
    q_sel = '0;
    // selects at or beyond the table read as an unset modulus
    for (int m = 0; m < NumModuli; m++) begin
      if (modulus_select_i == SelBits'(m)) begin
        q_sel = mod_q[m];
      end
    end
    is_nop  = (cmd == CmdNop);
    is_copy = (cmd == CmdAddImm) && (immediate_i == '0);
    is_mul0 = (cmd == CmdMulImm) && (immediate_i == '0);
    q_zero  = (q_sel == '0);

    ctl_d.cmd     = cmd;
    ctl_d.q       = q_sel;
    ctl_d.bypass  = is_nop || is_copy || is_mul0 || q_zero;
    ctl_d.err     = q_zero && !(is_nop || is_copy || is_mul0);
    ctl_d.byp_val = is_copy ? operand_a_i : '0;

    // two-operand commands use operand b, the rest the immediate
    y_sel = ((cmd == CmdAdd) || (cmd == CmdSub) || (cmd == CmdMul)) ?
            operand_b_i : immediate_i;
  end

  logic   ent_v_q;
  ctl_t   ent_ctl_q;
  coeff_t ent_x_q, ent_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else begin
      ent_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_ctl_q <= ctl_d;
    ent_x_q   <= operand_a_i;
    ent_y_q   <= y_sel;
  end

  // reduce both operands mod q
  logic   red_v;
  ctl_t   red_ctl;
  coeff_t red_x, red_y;

  mca_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ent_v_q),
    .in_ctl_i    (ent_ctl_q),
    .in_x_i      (ent_x_q),
    .in_y_i      (ent_y_q),
    .out_valid_o (red_v),
    .out_ctl_o   (red_ctl),
    .out_x_o     (red_x),
    .out_y_o     (red_y)
  );

  // modular product, operands carried alongside
  logic   mul_v;
  ctl_t   mul_ctl;
  coeff_t mul_x, mul_y, mul_p;

  mca_mulmod u_mulmod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_v),
    .in_ctl_i    (red_ctl),
    .in_x_i      (red_x),
    .in_y_i      (red_y),
    .out_valid_o (mul_v),
    .out_ctl_o   (mul_ctl),
    .out_x_o     (mul_x),
    .out_y_o     (mul_y),
    .out_prod_o  (mul_p)
  );

  // final stage: add / sub / negate and the result select
  coeff_t res_d;

  always_comb begin
    res_d = '0;
    if (mul_ctl.bypass) begin
      res_d = mul_ctl.byp_val;
    end else begin
      unique case (mul_ctl.cmd)
        CmdAdd, CmdAddImm: res_d = add_mod(mul_x, mul_y, mul_ctl.q);
        CmdSub, CmdSubImm: res_d = sub_mod(mul_x, mul_y, mul_ctl.q);
        CmdMul, CmdMulImm: res_d = mul_p;
        CmdNeg:            res_d = (mul_x == '0) ? '0 : (mul_ctl.q - mul_x);
        CmdNop:            res_d = '0;
        default:           res_d = '0;
      endcase
    end
  end

  logic   out_v_q;
  coeff_t res_q;
  logic   err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= mul_v;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    err_q <= mul_ctl.err;
  end

  assign result_valid_o  = out_v_q;
  assign result_o        = res_q;
  assign modulus_error_o = err_q;

  // an error result is always forced to zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && modulus_error_o |-> result_o == '0)
    else $error("modulus error with nonzero result");

  // every request comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency result_valid_o)
    else $error("result missing after request");

  // no result appears without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Latency !result_valid_o)
    else $error("result without request");

endmodule
